FILE: rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, register indexes and reset values of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int NUM_KEYS_DEF    = 4;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int KEY_FIELD_W = 4;
    localparam int PERIOD_W    = 8;
    localparam int START_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_SHORT_MIN     = 3'd0;
    localparam cfg_index_t CFG_SHORT_MAX     = 3'd1;
    localparam cfg_index_t CFG_LONG_PERIOD   = 3'd2;
    localparam cfg_index_t CFG_REPEAT_PERIOD = 3'd3;
    localparam cfg_index_t CFG_REPEAT_START  = 3'd4;
    localparam cfg_index_t CFG_REPEAT_MASK   = 3'd5;

    localparam logic [PERIOD_W-1:0]    SHORT_MIN_RST     = 8'd1;
    localparam logic [PERIOD_W-1:0]    SHORT_MAX_RST     = 8'd10;
    localparam logic [PERIOD_W-1:0]    LONG_PERIOD_RST   = 8'd20;
    localparam logic [PERIOD_W-1:0]    REPEAT_PERIOD_RST = 8'd4;
    localparam logic [START_W-1:0]     REPEAT_START_RST  = 16'd16;
    localparam logic [KEY_FIELD_W-1:0] REPEAT_MASK_RST   = 4'd12;

endpackage

FILE: rtl/key_press_classifier.sv
// ----------------------------------------------------------------------------
// key_press_classifier
// Per-key short press, long hold and autorepeat detection on scan ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, key_released) carries one scan tick per
//   transaction; bit i of key_released high means key i is released.
//   Output channel (out_valid, out_stall, press_events, long_events) returns
//   exactly one result per tick, in order.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes one
//   register per transaction; cfg_ready is always high, unknown indexes are
//   dropped. Write only while no tick is in flight.
//   The result is registered in the cycle after the tick transaction.
//   Throughput: one tick per cycle unless a result stalls; the per-key counter
//   update and compare logic sit between the input port and result register.
//   Reset clears all hold and phase counts and the result valid flag, and
//   loads the default register values.
//   While the receiver stalls a pending result, the result holds and
//   in_stall is raised, so no tick is lost.
// ----------------------------------------------------------------------------
module key_press_classifier #(
    parameter int NUM_KEYS    = kpc_pkg::NUM_KEYS_DEF,
    parameter int COUNT_WIDTH = kpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kpc_pkg::KEY_FIELD_W-1:0]   key_released,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kpc_pkg::KEY_FIELD_W-1:0]   press_events,
    output logic [kpc_pkg::KEY_FIELD_W-1:0]   long_events,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  kpc_pkg::cfg_index_t               cfg_index,
    input  logic [kpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PAD_W = (NUM_KEYS > kpc_pkg::KEY_FIELD_W) ? NUM_KEYS : kpc_pkg::KEY_FIELD_W;
    localparam int CMP_W = (COUNT_WIDTH > kpc_pkg::START_W) ? COUNT_WIDTH : kpc_pkg::START_W;
    localparam int PW    = kpc_pkg::PERIOD_W;

    logic [PW-1:0]                   short_min_reg;
    logic [PW-1:0]                   short_max_reg;
    logic [PW-1:0]                   long_period_reg;
    logic [PW-1:0]                   repeat_period_reg;
    logic [kpc_pkg::START_W-1:0]     repeat_start_reg;
    logic [kpc_pkg::KEY_FIELD_W-1:0] repeat_mask_reg;

    logic [COUNT_WIDTH-1:0] hold_count_reg  [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] hold_count_next [NUM_KEYS];
    logic [PW-1:0]          phase_count_reg  [NUM_KEYS];
    logic [PW-1:0]          phase_count_next [NUM_KEYS];
    logic [PW:0]            phase_sum [NUM_KEYS];
    logic [PW-1:0]          period    [NUM_KEYS];

    logic                            out_valid_reg;
    logic [kpc_pkg::KEY_FIELD_W-1:0] press_reg;
    logic [kpc_pkg::KEY_FIELD_W-1:0] long_reg;

    logic [PAD_W-1:0] levels_pad;
    logic [PAD_W-1:0] mode_pad;
    logic [PAD_W-1:0] press_next;
    logic [PAD_W-1:0] long_next;
    logic             in_accept;

    assign levels_pad = PAD_W'(key_released);
    assign mode_pad   = PAD_W'(repeat_mask_reg);
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;

    assign out_valid    = out_valid_reg;
    assign press_events = press_reg;
    assign long_events  = long_reg;

    // per-key counters and event decode
    always_comb
    begin
        press_next = '0;
        long_next  = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            period[k]    = mode_pad[k] ? repeat_period_reg : long_period_reg;
            phase_sum[k] = {1'b0, phase_count_reg[k]} + 1'b1;
            if (levels_pad[k])
            begin
                if ((CMP_W'(hold_count_reg[k]) > CMP_W'(short_min_reg)) &&
                    (CMP_W'(hold_count_reg[k]) < CMP_W'(short_max_reg)))
                begin
                    press_next[k] = 1'b1;
                end
                hold_count_next[k]  = '0;
                phase_count_next[k] = '0;
            end
            else
            begin
                hold_count_next[k] = (&hold_count_reg[k]) ? hold_count_reg[k]
                                                          : hold_count_reg[k] + 1'b1;
                if (phase_sum[k] >= {1'b0, period[k]})
                begin
                    phase_count_next[k] = '0;
                    if (mode_pad[k])
                    begin
                        press_next[k] = CMP_W'(hold_count_next[k]) >= CMP_W'(repeat_start_reg);
                    end
                    else
                    begin
                        long_next[k] = 1'b1;
                    end
                end
                else
                begin
                    phase_count_next[k] = phase_sum[k][PW-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg     <= kpc_pkg::SHORT_MIN_RST;
            short_max_reg     <= kpc_pkg::SHORT_MAX_RST;
            long_period_reg   <= kpc_pkg::LONG_PERIOD_RST;
            repeat_period_reg <= kpc_pkg::REPEAT_PERIOD_RST;
            repeat_start_reg  <= kpc_pkg::REPEAT_START_RST;
            repeat_mask_reg   <= kpc_pkg::REPEAT_MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                kpc_pkg::CFG_SHORT_MIN:     short_min_reg     <= cfg_data[PW-1:0];
                kpc_pkg::CFG_SHORT_MAX:     short_max_reg     <= cfg_data[PW-1:0];
                kpc_pkg::CFG_LONG_PERIOD:   long_period_reg   <= cfg_data[PW-1:0];
                kpc_pkg::CFG_REPEAT_PERIOD: repeat_period_reg <= cfg_data[PW-1:0];
                kpc_pkg::CFG_REPEAT_START:  repeat_start_reg  <= cfg_data[kpc_pkg::START_W-1:0];
                kpc_pkg::CFG_REPEAT_MASK:   repeat_mask_reg   <= cfg_data[kpc_pkg::KEY_FIELD_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hold_count_reg[k]  <= '0;
                phase_count_reg[k] <= '0;
            end
        end
        else if (in_accept)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                hold_count_reg[k]  <= hold_count_next[k];
                phase_count_reg[k] <= phase_count_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            press_reg <= press_next[kpc_pkg::KEY_FIELD_W-1:0];
            long_reg  <= long_next[kpc_pkg::KEY_FIELD_W-1:0];
        end
    end

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled without a pending result");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    a_events_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((press_reg & long_reg) == '0))
        else $error("press and long event on the same key");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && key_released[0]) |=> (hold_count_reg[0] == '0 && phase_count_reg[0] == '0))
        else $error("release did not clear key counts");

endmodule

FILE: tb/tb_key_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_press_classifier
// Self-checking testbench for the key press classifier. A queue-fed driver
// offers scan ticks, a monitor predicts the press and long-hold events of
// every accepted tick and checks each result transaction against them.
// Directed ticks and randomized hold/release sequences run under several
// register settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_key_press_classifier;

    localparam int KEYS        = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLDOFF_CYC = 150;

    localparam kpc_pkg::cfg_index_t CFG_SPARE_LO = 3'd6;
    localparam kpc_pkg::cfg_index_t CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [kpc_pkg::KEY_FIELD_W-1:0] press;
        logic [kpc_pkg::KEY_FIELD_W-1:0] hold_ev;
    } key_events_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [kpc_pkg::KEY_FIELD_W-1:0] key_released;
    logic                            out_valid;
    logic                            out_stall;
    logic [kpc_pkg::KEY_FIELD_W-1:0] press_events;
    logic [kpc_pkg::KEY_FIELD_W-1:0] long_events;
    logic                            cfg_valid;
    logic                            cfg_ready;
    kpc_pkg::cfg_index_t             cfg_index;
    logic [kpc_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic [kpc_pkg::KEY_FIELD_W-1:0] tick_queue[$];
    key_events_t                     expected_events[$];

    logic [kpc_pkg::PERIOD_W-1:0]    model_short_min;
    logic [kpc_pkg::PERIOD_W-1:0]    model_short_max;
    logic [kpc_pkg::PERIOD_W-1:0]    model_long_period;
    logic [kpc_pkg::PERIOD_W-1:0]    model_repeat_period;
    logic [kpc_pkg::START_W-1:0]     model_repeat_start;
    logic [kpc_pkg::KEY_FIELD_W-1:0] model_repeat_mask;
    logic [15:0]                     hold_cnt[KEYS];
    logic [7:0]                      phase_cnt[KEYS];

    logic                   key_held[KEYS];
    int                     run_left[KEYS];

    logic [kpc_pkg::KEY_FIELD_W-1:0] opening[17] = '{4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'hF,
                                                     4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0,
                                                     4'h0, 4'h0, 4'h5, 4'hA, 4'hF};
    int                     idle_send[4] = '{0, 60, 0, 36};
    int                     idle_recv[4] = '{0, 0, 60, 36};

    bit                     tick_sent;
    bit                     pressure_go;
    bit                     receiver_hold;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    int                     error_count;
    int                     cycle_count;

    key_press_classifier DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_released (key_released),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .press_events (press_events),
        .long_events  (long_events),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic reset_classifier_model();
        model_short_min     = kpc_pkg::SHORT_MIN_RST;
        model_short_max     = kpc_pkg::SHORT_MAX_RST;
        model_long_period   = kpc_pkg::LONG_PERIOD_RST;
        model_repeat_period = kpc_pkg::REPEAT_PERIOD_RST;
        model_repeat_start  = kpc_pkg::REPEAT_START_RST;
        model_repeat_mask   = kpc_pkg::REPEAT_MASK_RST;
        for (int k = 0; k < KEYS; k++)
        begin
            hold_cnt[k]  = '0;
            phase_cnt[k] = '0;
        end
    endtask

    task automatic apply_register(input kpc_pkg::cfg_index_t idx,
                                  input logic [kpc_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            kpc_pkg::CFG_SHORT_MIN:     model_short_min     = value[kpc_pkg::PERIOD_W-1:0];
            kpc_pkg::CFG_SHORT_MAX:     model_short_max     = value[kpc_pkg::PERIOD_W-1:0];
            kpc_pkg::CFG_LONG_PERIOD:   model_long_period   = value[kpc_pkg::PERIOD_W-1:0];
            kpc_pkg::CFG_REPEAT_PERIOD: model_repeat_period = value[kpc_pkg::PERIOD_W-1:0];
            kpc_pkg::CFG_REPEAT_START:  model_repeat_start  = value[kpc_pkg::START_W-1:0];
            kpc_pkg::CFG_REPEAT_MASK:   model_repeat_mask   = value[kpc_pkg::KEY_FIELD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic classify_tick(input logic [kpc_pkg::KEY_FIELD_W-1:0] levels,
                                 output key_events_t ev);
        int   ph;
        int   period;
        logic rep;
        ev = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            if (levels[k])
            begin
                if (hold_cnt[k] > model_short_min && hold_cnt[k] < model_short_max)
                    ev.press[k] = 1'b1;
                hold_cnt[k]  = '0;
                phase_cnt[k] = '0;
            end
            else
            begin
                rep    = model_repeat_mask[k];
                period = rep ? int'(model_repeat_period) : int'(model_long_period);
                ph     = int'(phase_cnt[k]) + 1;
                if (hold_cnt[k] != 16'hFFFF)
                    hold_cnt[k] = hold_cnt[k] + 16'd1;
                if (ph >= period)
                begin
                    ph = 0;
                    if (!rep)
                        ev.hold_ev[k] = 1'b1;
                    else if (hold_cnt[k] >= model_repeat_start)
                        ev.press[k] = 1'b1;
                end
                phase_cnt[k] = ph[7:0];
            end
        end
    endtask

    // tick driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            key_released <= '0;
        end
        else if (!in_valid || tick_sent)
        begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                key_released <= tick_queue.pop_front();
            end
            else
            begin
                in_valid     <= 1'b0;
                key_released <= 4'($urandom_range(15));
            end
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (receiver_hold)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // long receiver hold-off
    initial
    begin
        receiver_hold = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        receiver_hold = 1'b1;
        repeat (HOLDOFF_CYC) @(posedge clk);
        receiver_hold = 1'b0;
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        key_events_t exp_ev;
        key_events_t new_ev;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("result transaction with no tick pending: press=%h long=%h",
                           press_events, long_events);
                    error_count++;
                end
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (press_events !== exp_ev.press)
                    begin
                        $error("press_events: expected %h, got %h", exp_ev.press, press_events);
                        error_count++;
                    end
                    if (long_events !== exp_ev.hold_ev)
                    begin
                        $error("long_events: expected %h, got %h", exp_ev.hold_ev, long_events);
                        error_count++;
                    end
                end
            end
            tick_sent = in_valid && !in_stall;
            if (tick_sent)
            begin
                classify_tick(key_released, new_ev);
                expected_events.push_back(new_ev);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input kpc_pkg::cfg_index_t idx,
                             input logic [kpc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input int smin, input int smax, input int lper,
                               input int rper, input int rstart, input int mask);
        write_reg(kpc_pkg::CFG_SHORT_MIN,     kpc_pkg::CFG_DATA_W'(smin));
        write_reg(kpc_pkg::CFG_SHORT_MAX,     kpc_pkg::CFG_DATA_W'(smax));
        write_reg(kpc_pkg::CFG_LONG_PERIOD,   kpc_pkg::CFG_DATA_W'(lper));
        write_reg(kpc_pkg::CFG_REPEAT_PERIOD, kpc_pkg::CFG_DATA_W'(rper));
        write_reg(kpc_pkg::CFG_REPEAT_START,  kpc_pkg::CFG_DATA_W'(rstart));
        write_reg(kpc_pkg::CFG_REPEAT_MASK,   kpc_pkg::CFG_DATA_W'(mask));
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || in_valid || expected_events.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // hold/release runs per key, with some noise ticks
    task automatic queue_key_sequences(input int count);
        logic [kpc_pkg::KEY_FIELD_W-1:0] levels;
        int                              r;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(9) == 0)
                tick_queue.push_back(4'($urandom_range(15)));
            else
            begin
                for (int k = 0; k < KEYS; k++)
                begin
                    if (run_left[k] == 0)
                    begin
                        key_held[k] = !key_held[k];
                        r = $urandom_range(99);
                        if (!key_held[k])
                            run_left[k] = $urandom_range(1, 4);
                        else if (r < 60)
                            run_left[k] = $urandom_range(1, 12);
                        else if (r < 90)
                            run_left[k] = $urandom_range(13, 40);
                        else
                            run_left[k] = $urandom_range(41, 120);
                    end
                    levels[k] = !key_held[k];
                    run_left[k]--;
                end
                tick_queue.push_back(levels);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        key_released   = '0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = kpc_pkg::CFG_SHORT_MIN;
        cfg_data       = '0;
        tick_sent      = 1'b0;
        pressure_go    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        cycle_count    = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            key_held[k] = 1'b0;
            run_left[k] = 0;
        end
        reset_classifier_model();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // default settings, then zero long period and early autorepeat
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'hF);
        wait_idle();
        load_config(0, 3, 0, 1, 2, 4'b1010);
        foreach (opening[i])
            tick_queue.push_back(opening[i]);
        wait_idle();

        // unused indexes are dropped, data is masked to register width
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        write_reg(kpc_pkg::CFG_SHORT_MAX, 16'hFFFF);
        write_reg(kpc_pkg::CFG_LONG_PERIOD, 16'h000A);
        repeat (4) tick_queue.push_back(4'h0);
        wait_idle();

        // period shortened mid-hold fires at once
        write_reg(kpc_pkg::CFG_LONG_PERIOD, 16'h0002);
        tick_queue.push_back(4'h0);
        tick_queue.push_back(4'h3);
        tick_queue.push_back(4'hF);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                load_config(0, 0, 0, 0, 0, 0);
            else if (p == 1)
                load_config(255, 255, 255, 255, 16'hFFFF, 4'hF);
            else
                load_config($urandom_range(0, 6), $urandom_range(0, 20), $urandom_range(0, 12),
                            $urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(0, 15));
            send_idle_pct  = idle_send[p % 4];
            recv_stall_pct = idle_recv[p % 4];
            queue_key_sequences(200);
            wait_idle();
        end

        // receiver holds off while ticks keep coming
        load_config(1, 8, 3, 2, 5, $urandom_range(0, 15));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pressure_go    = 1'b1;
        queue_key_sequences(80);
        wait_idle();

        repeat (10) @(posedge clk);
        if (expected_events.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_events.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
